@@ rtl/cdte_pkg.sv @@
// ----------------------------------------------------------------------------
// cdte_pkg: calendar date and time editor package
// command codes, calendar constants and small calendar lookup functions
// ----------------------------------------------------------------------------
package cdte_pkg;

	// command codes carried by the func field
	typedef enum logic [3:0] {
		FN_LOAD     = 4'd0,
		FN_HOUR_DN  = 4'd1,
		FN_HOUR_UP  = 4'd2,
		FN_MIN_DN   = 4'd3,
		FN_MIN_UP   = 4'd4,
		FN_DAY_DN   = 4'd5,
		FN_DAY_UP   = 4'd6,
		FN_MON_DN   = 4'd7,
		FN_MON_UP   = 4'd8,
		FN_YEAR_DN  = 4'd9,
		FN_YEAR_UP  = 4'd10,
		FN_SAVE     = 4'd11,
		FN_CANCEL   = 4'd12
	} func_t;

	// years are held as an offset from the first supported year
	localparam logic [11:0] YEAR_FIRST     = 12'd1970;
	localparam logic [11:0] YEAR_LAST      = 12'd2069;
	localparam logic [6:0]  YEAR_OFF_LAST  = 7'd99;
	localparam logic [6:0]  YEAR_OFF_RESET = 7'd56;   // 2026

	localparam logic [4:0]  HOUR_LAST      = 5'd23;
	localparam logic [5:0]  MIN_LAST       = 6'd59;
	localparam logic [3:0]  MON_LAST       = 4'd12;
	localparam logic [4:0]  FALLBACK_HOUR  = 5'd12;

	// leap years in 1970..2069 are exactly those with offset mod 4 equal to 2
	function automatic logic is_leap(input logic [6:0] year_off);
		return year_off[1:0] == 2'd2;
	endfunction

	// days in a month; codes outside 1..12 read as january
	function automatic logic [4:0] mon_days(input logic [3:0] mon, input logic leap);
		logic [4:0] days;
		case (mon)
			4'd2:    days = leap ? 5'd29 : 5'd28;
			4'd4:    days = 5'd30;
			4'd6:    days = 5'd30;
			4'd9:    days = 5'd30;
			4'd11:   days = 5'd30;
			default: days = 5'd31;
		endcase
		return days;
	endfunction

	// month term of the day of week sum
	function automatic logic [2:0] month_offset(input logic [3:0] mon);
		logic [2:0] ofs;
		case (mon)
			4'd2:    ofs = 3'd3;
			4'd3:    ofs = 3'd2;
			4'd4:    ofs = 3'd5;
			4'd5:    ofs = 3'd0;
			4'd6:    ofs = 3'd3;
			4'd7:    ofs = 3'd5;
			4'd8:    ofs = 3'd1;
			4'd9:    ofs = 3'd4;
			4'd10:   ofs = 3'd6;
			4'd11:   ofs = 3'd2;
			4'd12:   ofs = 3'd4;
			default: ofs = 3'd0;
		endcase
		return ofs;
	endfunction

	// mod 7 by folding octal digits, since 8 is 1 mod 7
	function automatic logic [2:0] mod7(input logic [7:0] x);
		logic [4:0] fold_a;
		logic [3:0] fold_b;
		fold_a = {3'b000, x[7:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
		fold_b = {2'b00, fold_a[4:3]} + {1'b0, fold_a[2:0]};
		if (fold_b >= 4'd7) begin
			fold_b = fold_b - 4'd7;
		end
		return fold_b[2:0];
	endfunction

endpackage

@@ rtl/calendar_datetime_editor.sv @@
// ----------------------------------------------------------------------------
// calendar_datetime_editor: date and time editor for a real-time clock
// loads and checks a clock reading, steps its fields, computes day of week
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall carry one command item (func and the raw
//   clock reading used by a load). output channel: out_valid/out_stall carry
//   one result item per command: the edited date and time after the command,
//   the day of week and write_strobe on a save, and the editing flag.
//   path: an accepted item is registered in the input register, its result is
//   registered in the result register and shown from then on.
//   throughput: one item per cycle unless stalled; the whole update is one pass
//   of logic between the input register and the result register, and the edit
//   state is written in the same cycle as the result, so the next item sees it.
//   stalls: while out_stall holds a result, the waiting item stays in the
//   input register and in_stall rises; with both registers full nothing moves.
//   reset: arst_n clears both valid flags and puts the editor closed at
//   2026-01-01 00:00. load while open, edits while closed and unused codes
//   leave the state as it is but still give a result item.
// ----------------------------------------------------------------------------
module calendar_datetime_editor (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [11:0] load_year,
	input  logic [7:0]  load_month,
	input  logic [7:0]  load_day,
	input  logic [7:0]  load_weekday,
	input  logic [7:0]  load_hour,
	input  logic [7:0]  load_minute,
	input  logic [7:0]  load_second,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [11:0] year_out,
	output logic [2:0]  weekday_out,
	output logic        write_strobe,
	output logic        editing
);
	import cdte_pkg::*;

	// input register
	logic        valid_s1;
	logic [3:0]  func_s1;
	logic [11:0] year_s1;
	logic [7:0]  month_s1;
	logic [7:0]  day_s1;
	logic [7:0]  weekday_s1;
	logic [7:0]  hour_s1;
	logic [7:0]  minute_s1;
	logic [7:0]  second_s1;

	// edit state, year held as offset from 1970
	logic [4:0]  hr_q;
	logic [5:0]  min_q;
	logic [4:0]  dom_q;
	logic [3:0]  mon_q;
	logic [6:0]  yoff_q;
	logic        open_q;

	// next state and result fields
	logic [4:0]  hr_d;
	logic [5:0]  min_d;
	logic [4:0]  dom_d;
	logic [3:0]  mon_d;
	logic [6:0]  yoff_d;
	logic        open_d;
	logic [2:0]  wday_d;
	logic        strobe_d;

	// helper terms
	logic        accept;
	logic        advance;
	logic        leap_cur;
	logic        leap_new;
	logic [4:0]  dim_cur;
	logic [4:0]  dim_new;
	logic [3:0]  mon_step;
	logic [6:0]  yoff_step;
	logic        load_ok;
	logic [6:0]  load_yoff;
	logic [4:0]  load_dim;
	logic [6:0]  wk_year;
	logic [7:0]  wk_sum;

	// handshake: the result register frees when empty or taken
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= func;
			year_s1    <= load_year;
			month_s1   <= load_month;
			day_s1     <= load_day;
			weekday_s1 <= load_weekday;
			hour_s1    <= load_hour;
			minute_s1  <= load_minute;
			second_s1  <= load_second;
		end
	end

	// check of a raw reading; the leap test only matters once the year is in range
	always_comb begin
		load_yoff = 7'(year_s1 - YEAR_FIRST);
		load_dim  = mon_days(month_s1[3:0], is_leap(load_yoff));
		load_ok   = (hour_s1 < 8'd24) && (minute_s1 < 8'd60) && (second_s1 < 8'd60)
			&& (month_s1 >= 8'd1) && (month_s1 <= {4'd0, MON_LAST})
			&& (year_s1 >= YEAR_FIRST) && (year_s1 <= YEAR_LAST)
			&& (weekday_s1 <= 8'd6) && (day_s1 >= 8'd1)
			&& (day_s1 <= {3'd0, load_dim});
	end

	// month and year steps, with the month length after the step
	always_comb begin
		leap_cur = is_leap(yoff_q);
		dim_cur  = mon_days(mon_q, leap_cur);
		case (func_t'(func_s1))
			FN_MON_DN: mon_step = (mon_q <= 4'd1) ? MON_LAST : mon_q - 4'd1;
			FN_MON_UP: mon_step = (mon_q >= MON_LAST) ? 4'd1 : mon_q + 4'd1;
			default:   mon_step = mon_q;
		endcase
		case (func_t'(func_s1))
			FN_YEAR_DN: yoff_step = (yoff_q == 7'd0) ? YEAR_OFF_LAST : yoff_q - 7'd1;
			FN_YEAR_UP: yoff_step = (yoff_q >= YEAR_OFF_LAST) ? 7'd0 : yoff_q + 7'd1;
			default:    yoff_step = yoff_q;
		endcase
		leap_new = is_leap(yoff_step);
		dim_new  = mon_days(mon_step, leap_new);
	end

	// day of week: with the 1968 base the century terms cancel over 1969..2069,
	// leaving (2 + k + k/4 + month term + day) mod 7, k = year - 1968 (one less for jan and feb)
	always_comb begin
		wk_year = (mon_q < 4'd3) ? yoff_q + 7'd1 : yoff_q + 7'd2;
		wk_sum  = 8'd2 + {1'b0, wk_year} + {3'd0, wk_year[6:2]}
			+ {5'd0, month_offset(mon_q)} + {3'd0, dom_q};
	end

	// command decode
	always_comb begin
		hr_d     = hr_q;
		min_d    = min_q;
		dom_d    = dom_q;
		mon_d    = mon_q;
		yoff_d   = yoff_q;
		open_d   = open_q;
		wday_d   = 3'd0;
		strobe_d = 1'b0;
		if (func_t'(func_s1) == FN_LOAD) begin
			if (!open_q) begin
				open_d = 1'b1;
				if (load_ok) begin
					hr_d   = hour_s1[4:0];
					min_d  = minute_s1[5:0];
					dom_d  = day_s1[4:0];
					mon_d  = month_s1[3:0];
					yoff_d = load_yoff;
				end else begin
					hr_d   = FALLBACK_HOUR;
					min_d  = 6'd0;
					dom_d  = 5'd1;
					mon_d  = 4'd1;
					yoff_d = YEAR_OFF_RESET;
				end
			end
		end else if (open_q) begin
			case (func_t'(func_s1))
				FN_HOUR_DN: hr_d  = (hr_q == 5'd0) ? HOUR_LAST : hr_q - 5'd1;
				FN_HOUR_UP: hr_d  = (hr_q >= HOUR_LAST) ? 5'd0 : hr_q + 5'd1;
				FN_MIN_DN:  min_d = (min_q == 6'd0) ? MIN_LAST : min_q - 6'd1;
				FN_MIN_UP:  min_d = (min_q >= MIN_LAST) ? 6'd0 : min_q + 6'd1;
				FN_DAY_DN:  dom_d = (dom_q <= 5'd1) ? dim_cur : dom_q - 5'd1;
				FN_DAY_UP:  dom_d = (dom_q >= dim_cur) ? 5'd1 : dom_q + 5'd1;
				FN_MON_DN, FN_MON_UP, FN_YEAR_DN, FN_YEAR_UP: begin
					mon_d  = mon_step;
					yoff_d = yoff_step;
					dom_d  = (dom_q > dim_new) ? dim_new : dom_q;
				end
				FN_SAVE: begin
					wday_d   = mod7(wk_sum);
					strobe_d = 1'b1;
					open_d   = 1'b0;
				end
				FN_CANCEL: open_d = 1'b0;
				default: ;
			endcase
		end
	end

	// edit state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_q      <= 5'd0;
			min_q     <= 6'd0;
			dom_q     <= 5'd1;
			mon_q     <= 4'd1;
			yoff_q    <= YEAR_OFF_RESET;
			open_q    <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				hr_q   <= hr_d;
				min_q  <= min_d;
				dom_q  <= dom_d;
				mon_q  <= mon_d;
				yoff_q <= yoff_d;
				open_q <= open_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			hour_out     <= hr_d;
			minute_out   <= min_d;
			day_out      <= dom_d;
			month_out    <= mon_d;
			year_out     <= YEAR_FIRST + {5'd0, yoff_d};
			weekday_out  <= wday_d;
			write_strobe <= strobe_d;
			editing      <= open_d;
		end
	end

`ifndef SYNTHESIS
	// a save always closes the editor
	a_strobe_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_strobe |-> !editing)
		else $error("write strobe with editor still open");

	// a day of week is only reported on a save, and is 0..6
	a_weekday_save: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (weekday_out != 3'd0) |-> write_strobe && (weekday_out <= 3'd6))
		else $error("day of week outside a save");

	// edit state stays within the calendar
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hr_q <= HOUR_LAST) && (min_q <= MIN_LAST) && (mon_q >= 4'd1)
		&& (mon_q <= MON_LAST) && (yoff_q <= YEAR_OFF_LAST) && (dom_q >= 5'd1)
		&& (dom_q <= mon_days(mon_q, is_leap(yoff_q))))
		else $error("edit state out of range");

	// the input side only stalls while an item is held and the result is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule

@@ tb/calendar_datetime_editor_checker.sv @@
// ----------------------------------------------------------------------------
// calendar_datetime_editor_checker: scoreboard for the date and time editor
// tracks the edit state from accepted commands, predicts each result item and
// compares it field by field with what the editor sends
// ----------------------------------------------------------------------------
module calendar_datetime_editor_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  func,
	input  logic [11:0] load_year,
	input  logic [7:0]  load_month,
	input  logic [7:0]  load_day,
	input  logic [7:0]  load_weekday,
	input  logic [7:0]  load_hour,
	input  logic [7:0]  load_minute,
	input  logic [7:0]  load_second,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  hour_out,
	input  logic [5:0]  minute_out,
	input  logic [4:0]  day_out,
	input  logic [3:0]  month_out,
	input  logic [11:0] year_out,
	input  logic [2:0]  weekday_out,
	input  logic        write_strobe,
	input  logic        editing,
	output int          mismatches,
	output int          in_flight,
	output int          checked,
	output int          saves
);
	import cdte_pkg::*;

	localparam int RESET_YEAR    = 2026;
	localparam int FALLBACK_YEAR = 2026;
	localparam int FALLBACK_HR   = 12;

	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [2:0]  weekday;
		logic        strobe;
		logic        editing;
	} datetime_view_t;

	datetime_view_t view_q[$];
	datetime_view_t fresh_view;
	datetime_view_t oldest_view;

	int   cur_hour;
	int   cur_minute;
	int   cur_day;
	int   cur_month;
	int   cur_year;
	logic edit_open;

	initial begin
		mismatches = 0;
		checked    = 0;
		saves      = 0;
		in_flight  = 0;
	end

	function automatic int month_length(input int mon, input int yr);
		logic leap;
		leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		case (mon)
			2:           return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// month term of the weekday sum, january and february counted in the prior year
	function automatic int month_term(input int mon);
		case (mon)
			2, 6:    return 3;
			3, 11:   return 2;
			4, 7:    return 5;
			8:       return 1;
			9, 12:   return 4;
			10:      return 6;
			default: return 0;
		endcase
	endfunction

	function automatic int day_of_week(input int yr, input int mon, input int day);
		int y;
		y = (mon < 3) ? yr - 1 : yr;
		return (y + y / 4 - y / 100 + y / 400 + month_term(mon) + day) % 7;
	endfunction

	task automatic apply_command(
		input  logic [3:0]     code,
		input  logic [11:0]    ry,
		input  logic [7:0]     rmo,
		input  logic [7:0]     rd,
		input  logic [7:0]     rw,
		input  logic [7:0]     rh,
		input  logic [7:0]     rmi,
		input  logic [7:0]     rs,
		output datetime_view_t view
	);
		int   wd;
		logic strobe;
		logic good;
		wd = 0;
		strobe = 1'b0;
		if (code == FN_LOAD) begin
			if (!edit_open) begin
				good = rh < 24 && rmi < 60 && rs < 60 && rmo >= 1 && rmo <= 12 &&
					ry >= YEAR_FIRST && ry <= YEAR_LAST && rw <= 6 && rd >= 1 &&
					rd <= month_length(rmo, ry);
				if (good) begin
					cur_hour = rh;
					cur_minute = rmi;
					cur_day = rd;
					cur_month = rmo;
					cur_year = ry;
				end else begin
					cur_hour = FALLBACK_HR;
					cur_minute = 0;
					cur_day = 1;
					cur_month = 1;
					cur_year = FALLBACK_YEAR;
				end
				edit_open = 1'b1;
			end
		end else if (edit_open) begin
			case (code)
				FN_HOUR_DN: cur_hour = (cur_hour + 23) % 24;
				FN_HOUR_UP: cur_hour = (cur_hour + 1) % 24;
				FN_MIN_DN:  cur_minute = (cur_minute + 59) % 60;
				FN_MIN_UP:  cur_minute = (cur_minute + 1) % 60;
				FN_DAY_DN: begin
					if (cur_day <= 1) cur_day = month_length(cur_month, cur_year);
					else cur_day = cur_day - 1;
				end
				FN_DAY_UP: begin
					cur_day = cur_day + 1;
					if (cur_day > month_length(cur_month, cur_year)) cur_day = 1;
				end
				FN_MON_DN:  cur_month = (cur_month <= 1) ? 12 : cur_month - 1;
				FN_MON_UP:  cur_month = (cur_month >= 12) ? 1 : cur_month + 1;
				FN_YEAR_DN: cur_year = (cur_year <= YEAR_FIRST) ? YEAR_LAST : cur_year - 1;
				FN_YEAR_UP: cur_year = (cur_year >= YEAR_LAST) ? YEAR_FIRST : cur_year + 1;
				FN_SAVE: begin
					wd = day_of_week(cur_year, cur_month, cur_day);
					strobe = 1'b1;
					edit_open = 1'b0;
				end
				FN_CANCEL:  edit_open = 1'b0;
				default: ;
			endcase
			// month or year change pulls the day back into the new month
			if (cur_day > month_length(cur_month, cur_year))
				cur_day = month_length(cur_month, cur_year);
		end
		view.hour    = cur_hour[4:0];
		view.minute  = cur_minute[5:0];
		view.day     = cur_day[4:0];
		view.month   = cur_month[3:0];
		view.year    = cur_year[11:0];
		view.weekday = wd[2:0];
		view.strobe  = strobe;
		view.editing = edit_open;
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_hour   = 0;
			cur_minute = 0;
			cur_day    = 1;
			cur_month  = 1;
			cur_year   = RESET_YEAR;
			edit_open  = 1'b0;
			view_q.delete();
			in_flight <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_command(func, load_year, load_month, load_day, load_weekday,
					load_hour, load_minute, load_second, fresh_view);
				view_q.push_back(fresh_view);
			end
			if (out_valid && !out_stall) begin
				if (view_q.size() == 0) begin
					$display("%0t: result expected none got %0d:%0d %0d-%0d-%0d",
						$time, hour_out, minute_out, year_out, month_out, day_out);
					mismatches++;
				end else begin
					oldest_view = view_q.pop_front();
					compare_field("hour_out", oldest_view.hour, hour_out);
					compare_field("minute_out", oldest_view.minute, minute_out);
					compare_field("day_out", oldest_view.day, day_out);
					compare_field("month_out", oldest_view.month, month_out);
					compare_field("year_out", oldest_view.year, year_out);
					compare_field("weekday_out", oldest_view.weekday, weekday_out);
					compare_field("write_strobe", oldest_view.strobe, write_strobe);
					compare_field("editing", oldest_view.editing, editing);
					checked++;
					if (oldest_view.strobe) saves++;
				end
			end
			// registered copy so the stimulus side reads it free of races
			in_flight <= view_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the calendar date and time editor
// drives directed and random edit sessions through the command channel under
// several idle and stall mixes; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb;
	import cdte_pkg::*;

	// func codes the editor leaves unused
	localparam logic [3:0] FN_SPARE_FIRST = 4'd13;
	localparam logic [3:0] FN_SPARE_LAST  = 4'd15;

	localparam int QUIET_LIMIT  = 5000;   // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 8;      // settle time after the last result
	localparam int PHASE_ITEMS  = 320;

	typedef struct packed {
		logic [3:0]  code;
		logic [11:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  weekday;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
	} command_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [3:0]  func         = FN_LOAD;
	logic [11:0] load_year    = '0;
	logic [7:0]  load_month   = '0;
	logic [7:0]  load_day     = '0;
	logic [7:0]  load_weekday = '0;
	logic [7:0]  load_hour    = '0;
	logic [7:0]  load_minute  = '0;
	logic [7:0]  load_second  = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [11:0] year_out;
	logic [2:0]  weekday_out;
	logic        write_strobe;
	logic        editing;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int sent               = 0;
	int quiet              = 0;
	int mismatches;
	int in_flight;
	int checked;
	int saves;

	calendar_datetime_editor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.load_year    (load_year),
		.load_month   (load_month),
		.load_day     (load_day),
		.load_weekday (load_weekday),
		.load_hour    (load_hour),
		.load_minute  (load_minute),
		.load_second  (load_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hour_out     (hour_out),
		.minute_out   (minute_out),
		.day_out      (day_out),
		.month_out    (month_out),
		.year_out     (year_out),
		.weekday_out  (weekday_out),
		.write_strobe (write_strobe),
		.editing      (editing)
	);

	calendar_datetime_editor_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.load_year    (load_year),
		.load_month   (load_month),
		.load_day     (load_day),
		.load_weekday (load_weekday),
		.load_hour    (load_hour),
		.load_minute  (load_minute),
		.load_second  (load_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hour_out     (hour_out),
		.minute_out   (minute_out),
		.day_out      (day_out),
		.month_out    (month_out),
		.year_out     (year_out),
		.weekday_out  (weekday_out),
		.write_strobe (write_strobe),
		.editing      (editing),
		.mismatches   (mismatches),
		.in_flight    (in_flight),
		.checked      (checked),
		.saves        (saves)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side back-pressure, one fresh draw per cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// watchdog: any handshake on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// present one item, idling first at the current rate, and wait for acceptance
	task automatic send_command(input command_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= c.code;
		load_year    <= c.year;
		load_month   <= c.month;
		load_day     <= c.day;
		load_weekday <= c.weekday;
		load_hour    <= c.hour;
		load_minute  <= c.minute;
		load_second  <= c.second;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	// hold off the sender until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	// any command with random bits in the reading fields
	function automatic command_t noise_command(input logic [3:0] code);
		command_t c;
		c.code    = code;
		c.year    = 12'($urandom);
		c.month   = 8'($urandom);
		c.day     = 8'($urandom);
		c.weekday = 8'($urandom);
		c.hour    = 8'($urandom);
		c.minute  = 8'($urandom);
		c.second  = 8'($urandom);
		return c;
	endfunction

	function automatic command_t load_command(input int yr, input int mo, input int d,
		input int w, input int h, input int mi, input int s);
		command_t c;
		c.code    = FN_LOAD;
		c.year    = yr[11:0];
		c.month   = mo[7:0];
		c.day     = d[7:0];
		c.weekday = w[7:0];
		c.hour    = h[7:0];
		c.minute  = mi[7:0];
		c.second  = s[7:0];
		return c;
	endfunction

	// in range most of the time, now and then anything at or above the limit
	function automatic int mostly_below(input int limit);
		if ($urandom_range(29, 0) == 0) return $urandom_range(255, limit);
		return $urandom_range(limit - 1, 0);
	endfunction

	// clock reading that is usually valid, with years leaning toward the ends
	function automatic command_t plausible_reading();
		int yr;
		int mo;
		int d;
		if ($urandom_range(3, 0) == 0) begin
			if ($urandom_range(1, 0) == 0) yr = YEAR_FIRST + $urandom_range(1, 0);
			else yr = YEAR_LAST - $urandom_range(1, 0);
		end else begin
			yr = $urandom_range(YEAR_LAST, YEAR_FIRST);
		end
		mo = ($urandom_range(29, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(12, 1);
		// late days hit month ends and leap days, some of them invalid
		d = ($urandom_range(4, 0) == 0) ? $urandom_range(31, 29) : $urandom_range(28, 1);
		return load_command(yr, mo, d, mostly_below(7), mostly_below(24),
			mostly_below(60), mostly_below(60));
	endfunction

	// edit sessions: load, a run of edits, then save or cancel; stray items between
	task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
		int done;
		int edits;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		done = 0;
		while (done < quota) begin
			if ($urandom_range(99) < 12) begin
				send_command(noise_command(4'($urandom_range(FN_SPARE_LAST, FN_LOAD))));
			end else begin
				edits = $urandom_range(12, 0);
				if ($urandom_range(9, 0) == 0) send_command(noise_command(FN_LOAD));
				else send_command(plausible_reading());
				repeat (edits) begin
					send_command(noise_command(4'($urandom_range(FN_YEAR_UP, FN_HOUR_DN))));
				end
				if ($urandom_range(9, 0) < 7) send_command(noise_command(FN_SAVE));
				else send_command(noise_command(FN_CANCEL));
				done += edits + 2;
				if ($urandom_range(99) < 3) wait_drained();
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// closed editor ignores edits, save, cancel and spare codes
		send_command(noise_command(FN_SAVE));
		send_command(noise_command(FN_HOUR_UP));
		send_command(noise_command(FN_SPARE_FIRST));
		send_command(noise_command(FN_CANCEL));
		// all-zero reading is invalid and opens at the fallback
		send_command(load_command(0, 0, 0, 0, 0, 0, 0));
		// load while open is ignored
		send_command(load_command(4095, 255, 255, 255, 255, 255, 255));
		send_command(noise_command(FN_CANCEL));
		// all-ones reading, fallback again, then save it
		send_command(load_command(4095, 255, 255, 255, 255, 255, 255));
		send_command(noise_command(FN_SAVE));
		// leap day at the last minute, hour, minute and day each wrap
		send_command(load_command(2024, 2, 29, 6, 23, 59, 59));
		send_command(noise_command(FN_HOUR_UP));
		send_command(noise_command(FN_MIN_UP));
		send_command(noise_command(FN_HOUR_DN));
		send_command(noise_command(FN_MIN_DN));
		send_command(noise_command(FN_DAY_UP));
		send_command(noise_command(FN_DAY_DN));
		// next year has no leap day, the day is clamped
		send_command(noise_command(FN_YEAR_UP));
		send_command(noise_command(FN_SPARE_LAST));
		send_command(noise_command(FN_SAVE));
		// last supported day, year wraps both ways, month wraps and the day clamps
		send_command(load_command(YEAR_LAST, 12, 31, 0, 0, 0, 0));
		send_command(noise_command(FN_YEAR_UP));
		send_command(noise_command(FN_YEAR_DN));
		send_command(noise_command(FN_MON_UP));
		send_command(noise_command(FN_MON_UP));
		send_command(noise_command(FN_MON_DN));
		send_command(noise_command(FN_CANCEL));
		wait_drained();

		// handshake mixes: none, sender idle, receiver stall, both
		run_phase(0, 0, PHASE_ITEMS);
		run_phase(57, 0, PHASE_ITEMS);
		run_phase(0, 57, PHASE_ITEMS);
		run_phase(34, 34, PHASE_ITEMS);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run: %0d commands in four handshake mixes, %0d results compared",
			sent, checked);
		$display("run: %0d saves with write strobe, %0d field mismatches", saves, mismatches);
		if (mismatches == 0 && in_flight == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
